// ===== rtl/core/rcae_pkg.sv =====
// Package for the RGB color animation engine: payload types, event and mode
// codes, field widths, reset values and the hue wheel color function.
// No dependencies.
`timescale 1ns / 1ps

package rcae_pkg;

   // Field widths
   localparam int DUR_W        = 21;   // duration register
   localparam int DIV_W        = 32;   // serial divider dividend/quotient
   localparam int COLOR_W      = 32;
   localparam int BRIGHT_W     = 7;
   localparam int TIME_W_DEF   = 32;   // default time width

   // Reset and limit values
   localparam logic [DUR_W-1:0]    DUR_RESET    = 21'd4000;
   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd50;
   localparam logic [7:0]          BRIGHT_MAX   = 8'd100;

   // Reciprocal of 255 scaled by 2^23, exact for products up to 255*255
   localparam logic [15:0] RECIP_255  = 16'h8081;
   localparam int          RECIP_SHFT = 23;

   // Event kinds
   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_COLOR  = 2'd1;
   localparam logic [1:0] KIND_BRIGHT = 2'd2;
   localparam logic [1:0] KIND_MODE   = 2'd3;

   // Animation modes
   localparam logic [1:0] MODE_FIX   = 2'd0;
   localparam logic [1:0] MODE_FADE  = 2'd1;
   localparam logic [1:0] MODE_WHEEL = 2'd2;
   localparam logic [1:0] MODE_PULSE = 2'd3;

   // Hue wheel segments
   localparam logic [2:0] SEG_RG_UP   = 3'd0;
   localparam logic [2:0] SEG_R_DOWN  = 3'd1;
   localparam logic [2:0] SEG_B_UP    = 3'd2;
   localparam logic [2:0] SEG_G_DOWN  = 3'd3;
   localparam logic [2:0] SEG_R_UP    = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_ms;
      logic [31:0] color_word;
      logic [7:0]  brightness_in;
      logic [1:0]  mode_in;
   } req_type;

   typedef struct packed {
      logic [31:0]         color_out;
      logic [BRIGHT_W-1:0] brightness_out;
      logic                color_changed;
      logic                brightness_changed;
   } rsp_type;

   // Hue position (0..1535) to 0x00RRGGBB
   function automatic logic [COLOR_W-1:0] hue_color(input logic [10:0] hue);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] off;
      r   = 8'd0;
      g   = 8'd0;
      b   = 8'd0;
      off = hue[7:0];
      case (hue[10:8])
         SEG_RG_UP: begin
            r = 8'hFF; g = off;
         end
         SEG_R_DOWN: begin
            r = 8'hFF - off; g = 8'hFF;
         end
         SEG_B_UP: begin
            g = 8'hFF; b = off;
         end
         SEG_G_DOWN: begin
            g = 8'hFF - off; b = 8'hFF;
         end
         SEG_R_UP: begin
            r = off; b = 8'hFF;
         end
         default: begin
            b = 8'hFF - off; r = 8'hFF;
         end
      endcase
      return {8'h00, r, g, b};
   endfunction

endpackage

// ===== rtl/core/rgb_color_animation_engine_top.sv =====
// Top level of the RGB color animation engine: event handling, state,
// sequencer and result register. Depends on rcae_pkg, rcae_div, rcae_mix.
`timescale 1ns / 1ps

//  channel | ports                        | dir | carries
//  req     | req_valid/req_ready/req_data | in  | events (tick, color, brightness, mode)
//  rsp     | rsp_valid/rsp_ready/rsp_data | out | color and brightness updates
//  csr     | csr_valid/csr_ready/csr_wdata| in  | duration in ms
//
// Set events complete on accept. A fix tick goes straight to done; a fade tick
// in progress runs one serial division plus five blend passes, a pulse tick
// two serial divisions plus five blend passes and a wheel tick two serial
// divisions. Reset is synchronous; no clearing pass. A stalled rsp holds the
// result register, and a finished tick waits for it before the next accept.

module rgb_color_animation_engine_top
   import rcae_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_W_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [DUR_W-1:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MOD  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MIX  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;
   localparam logic [2:0] CH_BRIGHT = 3'd4;

   // Control state
   logic [2:0]            state_ff;
   logic [DUR_W-1:0]      duration_ff;
   logic [1:0]            mode_ff;
   logic                  cpend_ff;
   logic                  bpend_ff;
   logic                  rsp_valid_ff;
   logic                  div_go_ff;
   logic                  mix_go_ff;
   logic [2:0]            ch_ff;

   // Animation state
   logic [COLOR_W-1:0]    shown_c_ff;
   logic [COLOR_W-1:0]    goal_c_ff;
   logic [COLOR_W-1:0]    orig_c_ff;
   logic [BRIGHT_W-1:0]   shown_b_ff;
   logic [BRIGHT_W-1:0]   goal_b_ff;
   logic [BRIGHT_W-1:0]   orig_b_ff;
   logic [TIME_WIDTH-1:0] start_ff;

   // Work registers
   logic [COLOR_W-1:0]    next_c_ff;
   logic [BRIGHT_W-1:0]   next_b_ff;
   logic [DIV_W-1:0]      div_arg_ff;
   logic [7:0]            factor_ff;
   rsp_type               rsp_ff;

   logic [TIME_WIDTH-1:0] now_tw;
   logic [TIME_WIDTH-1:0] elapsed;
   logic [DUR_W-1:0]      dur_eff;
   logic                  accept;
   logic                  emit;
   logic                  div_done;
   logic [DIV_W-1:0]      div_quot;
   logic [DUR_W-1:0]      div_rem;
   logic [DIV_W-1:0]      rem_ext;
   logic [8:0]            level;
   logic [7:0]            level_fold;
   logic [7:0]            mix_a;
   logic [7:0]            mix_b;
   logic                  mix_valid;
   logic [7:0]            mix_out;
   logic [7:0]            bright_clamp;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      now_tw       = req_data.now_ms[TIME_WIDTH-1:0];
      elapsed      = now_tw - start_ff;
      dur_eff      = (duration_ff == '0) ? DUR_W'(1) : duration_ff;
      rem_ext      = DIV_W'(div_rem);
      level        = div_quot[8:0];
      level_fold   = (level > 9'd255) ? 8'(9'd510 - level) : level[7:0];
      bright_clamp = (req_data.brightness_in > BRIGHT_MAX) ? BRIGHT_MAX
                                                           : req_data.brightness_in;
      emit         = (state_ff == ST_DONE) && (cpend_ff || bpend_ff)
                     && (!rsp_valid_ff || rsp_ready);
   end

   // Blend operands for the current channel
   always_comb begin
      if (ch_ff == CH_BRIGHT) begin
         mix_b = {1'b0, goal_b_ff};
         mix_a = (mode_ff == MODE_FADE) ? {1'b0, orig_b_ff} : {1'b0, goal_b_ff};
      end else begin
         mix_b = goal_c_ff[8*ch_ff[1:0] +: 8];
         mix_a = (mode_ff == MODE_FADE) ? orig_c_ff[8*ch_ff[1:0] +: 8] : 8'd0;
      end
   end

   rcae_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go_ff),
      .dividend  (div_arg_ff),
      .divisor   (dur_eff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   rcae_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .start    (mix_go_ff),
      .chan_a   (mix_a),
      .chan_b   (mix_b),
      .factor   (factor_ff),
      .valid    (mix_valid),
      .chan_out (mix_out)
   );

   // Sequencer and state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         duration_ff  <= DUR_RESET;
         mode_ff      <= MODE_FIX;
         cpend_ff     <= 1'b0;
         bpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
         mix_go_ff    <= 1'b0;
         ch_ff        <= '0;
         shown_c_ff   <= '0;
         goal_c_ff    <= '0;
         orig_c_ff    <= '0;
         shown_b_ff   <= BRIGHT_RESET;
         goal_b_ff    <= BRIGHT_RESET;
         orig_b_ff    <= BRIGHT_RESET;
         start_ff     <= '0;
      end else begin
         div_go_ff <= 1'b0;
         mix_go_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            duration_ff <= csr_wdata;
         end
         // Result valid: set on emit, cleared on transfer
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_data.kind)
                     KIND_COLOR: begin
                        if (mode_ff == MODE_FADE) begin
                           orig_c_ff <= shown_c_ff;
                           orig_b_ff <= shown_b_ff;
                           start_ff  <= now_tw;
                        end
                        goal_c_ff <= req_data.color_word;
                        goal_b_ff <= shown_b_ff;
                        cpend_ff  <= 1'b1;
                     end
                     KIND_BRIGHT: begin
                        orig_b_ff <= shown_b_ff;
                        goal_b_ff <= bright_clamp[BRIGHT_W-1:0];
                        start_ff  <= now_tw;
                        bpend_ff  <= 1'b1;
                     end
                     KIND_MODE: begin
                        mode_ff   <= req_data.mode_in;
                        goal_c_ff <= shown_c_ff;
                        start_ff  <= now_tw;
                        cpend_ff  <= 1'b1;
                        bpend_ff  <= 1'b1;
                     end
                     default: begin
                        // tick
                        next_c_ff <= goal_c_ff;
                        next_b_ff <= goal_b_ff;
                        state_ff  <= ST_DONE;
                        unique case (mode_ff)
                           MODE_FIX: begin
                              if (shown_c_ff != goal_c_ff) cpend_ff <= 1'b1;
                           end
                           MODE_FADE: begin
                              if (shown_c_ff != goal_c_ff || shown_b_ff != goal_b_ff) begin
                                 cpend_ff <= 1'b1;
                                 bpend_ff <= 1'b1;
                                 if (DIV_W'(elapsed) < DIV_W'(dur_eff)) begin
                                    div_arg_ff <= (DIV_W'(elapsed) << 8) - DIV_W'(elapsed);
                                    div_go_ff  <= 1'b1;
                                    state_ff   <= ST_DIV;
                                 end
                              end
                           end
                           default: begin
                              // pulse and wheel: phase = now mod duration
                              cpend_ff   <= 1'b1;
                              div_arg_ff <= DIV_W'(now_tw);
                              div_go_ff  <= 1'b1;
                              state_ff   <= ST_MOD;
                           end
                        endcase
                     end
                  endcase
               end
            end
            ST_MOD: begin
               if (div_done) begin
                  if (mode_ff == MODE_PULSE) begin
                     div_arg_ff <= (rem_ext << 9) - (rem_ext << 1);
                  end else begin
                     div_arg_ff <= (rem_ext << 10) + (rem_ext << 9);
                  end
                  div_go_ff <= 1'b1;
                  state_ff  <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  ch_ff <= '0;
                  unique case (mode_ff)
                     MODE_FADE: begin
                        factor_ff <= div_quot[7:0];
                        mix_go_ff <= 1'b1;
                        state_ff  <= ST_MIX;
                     end
                     MODE_PULSE: begin
                        factor_ff <= level_fold;
                        mix_go_ff <= 1'b1;
                        state_ff  <= ST_MIX;
                     end
                     default: begin
                        next_c_ff <= hue_color(div_quot[10:0]);
                        state_ff  <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_MIX: begin
               if (mix_valid) begin
                  if (ch_ff == CH_BRIGHT) begin
                     next_b_ff <= mix_out[BRIGHT_W-1:0];
                     state_ff  <= ST_DONE;
                  end else begin
                     next_c_ff[8*ch_ff[1:0] +: 8] <= mix_out;
                     ch_ff     <= ch_ff + 1'b1;
                     mix_go_ff <= 1'b1;
                  end
               end
            end
            ST_DONE: begin
               if (!(cpend_ff || bpend_ff)) begin
                  state_ff <= ST_IDLE;
               end else if (emit) begin
                  shown_c_ff   <= next_c_ff;
                  if (bpend_ff) shown_b_ff <= next_b_ff;
                  cpend_ff     <= 1'b0;
                  bpend_ff     <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff.color_out          <= next_c_ff;
         rsp_ff.brightness_out     <= next_b_ff;
         rsp_ff.color_changed      <= cpend_ff;
         rsp_ff.brightness_changed <= bpend_ff;
      end
   end

endmodule

// ===== rtl/core/rcae_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on rcae_pkg (DIV_W, DUR_W).
`timescale 1ns / 1ps

module rcae_div
   import rcae_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DUR_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [DUR_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff;
   logic [DUR_W-1:0] rem_ff;
   logic [DUR_W-1:0] dsr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DUR_W:0]   shifted;
   logic [DUR_W:0]   trial;
   logic             fits;

   // One restoring step
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      trial   = shifted - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? trial[DUR_W-1:0] : shifted[DUR_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/rcae_mix.sv =====
// Two-stage channel blend: c = a + trunc((b - a) * f / 255), 8-bit channels.
// Depends on rcae_pkg (RECIP_255, RECIP_SHFT).
`timescale 1ns / 1ps

module rcae_mix
   import rcae_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] chan_a,
   input  logic [7:0] chan_b,
   input  logic [7:0] factor,
   output logic       valid,
   output logic [7:0] chan_out
);

   logic        v1_ff;
   logic        v2_ff;
   logic [15:0] prod_ff;
   logic        neg_ff;
   logic [7:0]  a_ff;
   logic [7:0]  c_ff;

   logic        neg;
   logic [7:0]  mag;
   logic [31:0] scaled;
   logic [7:0]  quot;

   always_comb begin
      neg    = chan_b < chan_a;
      mag    = neg ? (chan_a - chan_b) : (chan_b - chan_a);
      scaled = prod_ff * RECIP_255;
      quot   = scaled[RECIP_SHFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
   end

   // Stage 1: magnitude times factor; stage 2: divide by 255, apply sign
   always_ff @(posedge clock) begin
      prod_ff <= mag * factor;
      neg_ff  <= neg;
      a_ff    <= chan_a;
      c_ff    <= neg_ff ? (a_ff - quot) : (a_ff + quot);
   end

   assign valid    = v2_ff;
   assign chan_out = c_ff;

endmodule
